// ===== design/a1rp_pkg.sv =====
// Package: widths, limits and character codes of the A1 reference parser.
package a1rp_pkg;

    localparam int MAX_ROWS = 1048576;
    localparam int MAX_COLS = 16384;

    localparam int ROW_W    = 20;
    localparam int COL_W    = 14;
    localparam int CACC_W   = 15;
    localparam int RACC_W   = 21;
    localparam int CPROD_W  = CACC_W + 5;
    localparam int RPROD_W  = RACC_W + 4;
    localparam int RUN_W    = 4;

    localparam logic [RUN_W-1:0] MAX_LETTERS = RUN_W'(3);
    localparam logic [RUN_W-1:0] MAX_DIGITS  = RUN_W'(7);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h27;

    // acc * 26 + letter value; the low five bits of an ASCII letter are its 1-based index
    function automatic logic [CPROD_W-1:0] f_col_mac(input logic [CACC_W-1:0] acc,
                                                     input logic [7:0] ch);
        f_col_mac = CPROD_W'(acc) * CPROD_W'(26) + CPROD_W'(ch[4:0]);
    endfunction

    function automatic logic [RPROD_W-1:0] f_row_mac(input logic [RACC_W-1:0] acc,
                                                     input logic [7:0] ch);
        f_row_mac = RPROD_W'(acc) * RPROD_W'(10) + RPROD_W'(ch[3:0]);
    endfunction

endpackage

// ===== design/a1rp_if.sv =====
// Interfaces: character request channel and parse result channel.
interface a1rp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface a1rp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         valid_res;
    logic [a1rp_pkg::ROW_W-1:0]   first_row;
    logic [a1rp_pkg::COL_W-1:0]   first_col;
    logic [a1rp_pkg::ROW_W-1:0]   second_row;
    logic [a1rp_pkg::COL_W-1:0]   second_col;
    logic                         range_form;
    logic                         whole_column;
    logic                         whole_row;
    logic                         sheet_given;

    modport source (output valid, output valid_res, output first_row, output first_col,
                    output second_row, output second_col, output range_form,
                    output whole_column, output whole_row, output sheet_given,
                    input ready);
    modport sink   (input valid, input valid_res, input first_row, input first_col,
                    input second_row, input second_col, input range_form,
                    input whole_column, input whole_row, input sheet_given,
                    output ready);
endinterface

// ===== design/a1_reference_parser.sv =====
// A1 reference parser: streaming character parser with registered result.
// One character request is taken per cycle, back to back; the parse state is
// updated once per character and the result of a text appears in
// the output register the cycle after its last character. Characters that end
// no text are taken even while a result waits; a last character waits only
// until the output register is free. No memory, no clearing pass after reset.
module a1_reference_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    a1rp_in_if.sink       i_in,
    a1rp_out_if.source    o_out
);
    import a1rp_pkg::*;

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_DOL1    = 4'd1;
    localparam logic [3:0] PH_L1      = 4'd2;
    localparam logic [3:0] PH_DOL1R   = 4'd3;
    localparam logic [3:0] PH_CR1     = 4'd4;
    localparam logic [3:0] PH_D1      = 4'd5;
    localparam logic [3:0] PH_SEC     = 4'd6;
    localparam logic [3:0] PH_SECDOL  = 4'd7;
    localparam logic [3:0] PH_SECL    = 4'd8;
    localparam logic [3:0] PH_SECDOLR = 4'd9;
    localparam logic [3:0] PH_SECD    = 4'd10;
    localparam logic [3:0] PH_DEAD    = 4'd11;
    localparam logic [3:0] PH_QUOTE   = 4'd12;
    localparam logic [3:0] PH_QPEND   = 4'd13;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_COL  = 2'd1;
    localparam logic [1:0] KIND_ROW  = 2'd2;
    localparam logic [1:0] KIND_CELL = 2'd3;

    logic [3:0]        r_phase, s_phase, n_phase;
    logic [CACC_W-1:0] r_ca, s_ca, n_ca, r_cb, s_cb, n_cb;
    logic [RACC_W-1:0] r_ra, s_ra, n_ra, r_rb, s_rb, n_rb;
    logic [RUN_W-1:0]  r_rc, s_rc, n_rc;
    logic              r_mid, s_mid, n_mid;
    logic              r_prefix, s_prefix, n_prefix;
    logic              r_sheet, s_sheet, n_sheet;
    logic [1:0]        r_kind, s_kind, n_kind;

    logic              r_out_valid;
    logic              r_valid_res, n_valid_res;
    logic [ROW_W-1:0]  r_first_row, n_first_row, r_second_row, n_second_row;
    logic [COL_W-1:0]  r_first_col, n_first_col, r_second_col, n_second_col;
    logic              r_range, n_range, r_wcol, n_wcol, r_wrow, n_wrow;
    logic              r_sheet_out, n_sheet_out;

    logic [7:0]        ch;
    logic              is_let, is_dig, is_word;
    logic              take_l, take_d, to_b, fresh, clr;
    logic [3:0]        nxt;
    logic [RUN_W-1:0]  rc_inc;
    logic [CPROD_W-1:0] col_n;
    logic [RPROD_W-1:0] row_n;
    logic              acc_req, acc_last;

    assign ch       = i_in.char_code;
    assign is_let   = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    assign is_dig   = ch >= 8'h30 && ch <= 8'h39;
    assign is_word  = is_let || is_dig || ch == CH_USCORE;

    assign i_in.ready = !r_out_valid || o_out.ready || !i_in.last_char;
    assign acc_req    = i_in.valid && i_in.ready;
    assign acc_last   = acc_req && i_in.last_char;

    always_comb begin
        s_phase  = r_phase;
        s_ca     = r_ca;
        s_cb     = r_cb;
        s_ra     = r_ra;
        s_rb     = r_rb;
        s_rc     = r_rc;
        s_prefix = r_prefix;
        s_sheet  = r_sheet;
        s_kind   = r_kind;
        take_l   = 1'b0;
        take_d   = 1'b0;
        to_b     = 1'b0;
        fresh    = 1'b0;
        clr      = 1'b0;
        nxt      = r_phase;
        rc_inc   = '0;
        col_n    = '0;
        row_n    = '0;

        if (!r_mid && ch == CH_QUOTE) begin
            s_phase  = PH_QUOTE;
            s_prefix = 1'b0;
        end else if (r_phase == PH_QUOTE) begin
            if (ch == CH_QUOTE) s_phase = PH_QPEND;
        end else if (r_phase == PH_QPEND) begin
            if (ch == CH_QUOTE) begin
                s_phase = PH_QUOTE;
            end else if (ch == CH_BANG) begin
                clr     = 1'b1;
                s_sheet = 1'b1;
            end else begin
                s_phase = PH_DEAD;
            end
        end else if (r_mid && ch == CH_BANG && r_prefix) begin
            clr      = 1'b1;
            s_prefix = 1'b0;
            s_sheet  = 1'b1;
        end else begin
            s_prefix = is_word && (!r_mid || r_prefix);
            case (r_phase)
                PH_START, PH_DOL1: begin
                    if (ch == CH_DOLLAR && r_phase == PH_START) s_phase = PH_DOL1;
                    else if (is_let) begin
                        take_l = 1'b1; fresh = 1'b1; nxt = PH_L1;
                    end else if (is_dig) begin
                        take_d = 1'b1; fresh = 1'b1; nxt = PH_D1;
                    end else s_phase = PH_DEAD;
                end
                PH_L1: begin
                    if (is_let) begin
                        take_l = 1'b1; nxt = PH_L1;
                    end else if (ch == CH_DOLLAR) s_phase = PH_DOL1R;
                    else if (is_dig) begin
                        take_d = 1'b1; fresh = 1'b1; nxt = PH_CR1;
                    end else if (ch == CH_COLON) begin
                        s_kind = KIND_COL; s_phase = PH_SEC;
                    end else s_phase = PH_DEAD;
                end
                PH_DOL1R: begin
                    if (is_dig) begin
                        take_d = 1'b1; fresh = 1'b1; nxt = PH_CR1;
                    end else s_phase = PH_DEAD;
                end
                PH_CR1, PH_D1: begin
                    if (is_dig) begin
                        take_d = 1'b1; nxt = r_phase;
                    end else if (ch == CH_COLON && r_ra != '0) begin
                        s_kind  = (r_phase == PH_CR1) ? KIND_CELL : KIND_ROW;
                        s_phase = PH_SEC;
                    end else s_phase = PH_DEAD;
                end
                PH_SEC, PH_SECDOL: begin
                    if (ch == CH_DOLLAR && r_phase == PH_SEC) s_phase = PH_SECDOL;
                    else if (is_let && r_kind != KIND_ROW) begin
                        take_l = 1'b1; to_b = 1'b1; fresh = 1'b1; nxt = PH_SECL;
                    end else if (is_dig && r_kind == KIND_ROW) begin
                        take_d = 1'b1; to_b = 1'b1; fresh = 1'b1; nxt = PH_SECD;
                    end else s_phase = PH_DEAD;
                end
                PH_SECL: begin
                    if (is_let) begin
                        take_l = 1'b1; to_b = 1'b1; nxt = PH_SECL;
                    end else if (r_kind == KIND_CELL && ch == CH_DOLLAR) s_phase = PH_SECDOLR;
                    else if (r_kind == KIND_CELL && is_dig) begin
                        take_d = 1'b1; to_b = 1'b1; fresh = 1'b1; nxt = PH_SECD;
                    end else s_phase = PH_DEAD;
                end
                PH_SECDOLR: begin
                    if (is_dig) begin
                        take_d = 1'b1; to_b = 1'b1; fresh = 1'b1; nxt = PH_SECD;
                    end else s_phase = PH_DEAD;
                end
                PH_SECD: begin
                    if (is_dig) begin
                        take_d = 1'b1; to_b = 1'b1; nxt = PH_SECD;
                    end else s_phase = PH_DEAD;
                end
                default: s_phase = PH_DEAD;
            endcase
        end

        rc_inc = (fresh ? '0 : r_rc) + RUN_W'(1);
        if (take_l) begin
            col_n = f_col_mac(to_b ? r_cb : r_ca, ch);
            s_rc  = rc_inc;
            if (rc_inc > MAX_LETTERS || col_n > CPROD_W'(MAX_COLS)) begin
                s_phase = PH_DEAD;
            end else begin
                s_phase = nxt;
                if (to_b) s_cb = col_n[CACC_W-1:0];
                else      s_ca = col_n[CACC_W-1:0];
            end
        end
        if (take_d) begin
            row_n = f_row_mac(to_b ? r_rb : r_ra, ch);
            s_rc  = rc_inc;
            if (rc_inc > MAX_DIGITS || row_n > RPROD_W'(MAX_ROWS)) begin
                s_phase = PH_DEAD;
            end else begin
                s_phase = nxt;
                if (to_b) s_rb = row_n[RACC_W-1:0];
                else      s_ra = row_n[RACC_W-1:0];
            end
        end

        if (clr) begin
            s_phase = PH_START;
            s_ca    = '0;
            s_cb    = '0;
            s_ra    = '0;
            s_rb    = '0;
            s_rc    = '0;
            s_kind  = KIND_NONE;
        end
        s_mid = 1'b1;
    end

    // Result of the text, taken from the state after its last character
    always_comb begin
        logic [CACC_W-1:0] c_lo, c_hi;
        logic [RACC_W-1:0] r_lo, r_hi;
        c_lo = (s_ca < s_cb) ? s_ca : s_cb;
        c_hi = (s_ca < s_cb) ? s_cb : s_ca;
        r_lo = (s_ra < s_rb) ? s_ra : s_rb;
        r_hi = (s_ra < s_rb) ? s_rb : s_ra;
        n_valid_res  = 1'b0;
        n_first_row  = '0;
        n_first_col  = '0;
        n_second_row = '0;
        n_second_col = '0;
        n_range      = 1'b0;
        n_wcol       = 1'b0;
        n_wrow       = 1'b0;
        if (s_phase == PH_CR1 && s_ra != '0) begin
            n_valid_res = 1'b1;
            n_first_row = ROW_W'(s_ra - RACC_W'(1));
            n_first_col = COL_W'(s_ca - CACC_W'(1));
        end else if (s_phase == PH_SECL && s_kind == KIND_COL) begin
            n_valid_res  = 1'b1;
            n_range      = 1'b1;
            n_wcol       = 1'b1;
            n_first_col  = COL_W'(c_lo - CACC_W'(1));
            n_second_col = COL_W'(c_hi - CACC_W'(1));
            n_second_row = ROW_W'(MAX_ROWS - 1);
        end else if (s_phase == PH_SECD && s_rb != '0 && s_kind == KIND_ROW) begin
            n_valid_res  = 1'b1;
            n_range      = 1'b1;
            n_wrow       = 1'b1;
            n_first_row  = ROW_W'(r_lo - RACC_W'(1));
            n_second_row = ROW_W'(r_hi - RACC_W'(1));
            n_second_col = COL_W'(MAX_COLS - 1);
        end else if (s_phase == PH_SECD && s_rb != '0 && s_kind == KIND_CELL) begin
            n_valid_res  = 1'b1;
            n_range      = 1'b1;
            n_first_row  = ROW_W'(s_ra - RACC_W'(1));
            n_first_col  = COL_W'(s_ca - CACC_W'(1));
            n_second_row = ROW_W'(s_rb - RACC_W'(1));
            n_second_col = COL_W'(s_cb - CACC_W'(1));
        end
        n_sheet_out = n_valid_res && s_sheet;
    end

    // A last character returns the parser to its reset state
    always_comb begin
        if (i_in.last_char) begin
            n_phase  = PH_START;
            n_ca     = '0;
            n_cb     = '0;
            n_ra     = '0;
            n_rb     = '0;
            n_rc     = '0;
            n_mid    = 1'b0;
            n_prefix = 1'b0;
            n_sheet  = 1'b0;
            n_kind   = KIND_NONE;
        end else begin
            n_phase  = s_phase;
            n_ca     = s_ca;
            n_cb     = s_cb;
            n_ra     = s_ra;
            n_rb     = s_rb;
            n_rc     = s_rc;
            n_mid    = s_mid;
            n_prefix = s_prefix;
            n_sheet  = s_sheet;
            n_kind   = s_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_ca     <= '0;
            r_cb     <= '0;
            r_ra     <= '0;
            r_rb     <= '0;
            r_rc     <= '0;
            r_mid    <= 1'b0;
            r_prefix <= 1'b0;
            r_sheet  <= 1'b0;
            r_kind   <= KIND_NONE;
        end else if (acc_req) begin
            r_phase  <= n_phase;
            r_ca     <= n_ca;
            r_cb     <= n_cb;
            r_ra     <= n_ra;
            r_rb     <= n_rb;
            r_rc     <= n_rc;
            r_mid    <= n_mid;
            r_prefix <= n_prefix;
            r_sheet  <= n_sheet;
            r_kind   <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_last) begin
            r_valid_res  <= n_valid_res;
            r_first_row  <= n_first_row;
            r_first_col  <= n_first_col;
            r_second_row <= n_second_row;
            r_second_col <= n_second_col;
            r_range      <= n_range;
            r_wcol       <= n_wcol;
            r_wrow       <= n_wrow;
            r_sheet_out  <= n_sheet_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.valid_res    = r_valid_res;
    assign o_out.first_row    = r_first_row;
    assign o_out.first_col    = r_first_col;
    assign o_out.second_row   = r_second_row;
    assign o_out.second_col   = r_second_col;
    assign o_out.range_form   = r_range;
    assign o_out.whole_column = r_wcol;
    assign o_out.whole_row    = r_wrow;
    assign o_out.sheet_given  = r_sheet_out;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_last |=> r_out_valid)
        else $error("no result after last character");

    a_last_resets_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_last |=> (r_phase == PH_START && !r_mid && !r_sheet && r_kind == KIND_NONE))
        else $error("parse state not cleared after last character");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_valid_res) |-> (r_first_row == '0 && r_first_col == '0 &&
            r_second_row == '0 && r_second_col == '0 && !r_range && !r_sheet_out))
        else $error("invalid result carries nonzero fields");

    a_span_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!(r_wcol && r_wrow) && (!(r_wcol || r_wrow) || r_range)))
        else $error("inconsistent span flags");

    a_second_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEC || r_phase == PH_SECL || r_phase == PH_SECD) |->
            r_kind != KIND_NONE)
        else $error("second part without form");

endmodule
